### src/esc_pkg.sv
// ============================================================================
// esc_pkg: shared types and constants for the engine start controller
// Holds the phase codes, the command/status structs and register indexes.
// ============================================================================
package esc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned TimerW = 17;
    localparam int unsigned TotalW = 20;
    localparam int unsigned RpmW = 16;
    localparam int unsigned DivW = 36;   // spark_total * 60000 fits in 36 bits
    localparam int unsigned DenW = 21;   // sparks_per_rev * window fits in 21 bits
    localparam logic [TimerW-1:0] TimerMax = '1;
    localparam logic [TotalW-1:0] TotalMax = '1;
    localparam logic [15:0] RpmScale = 16'd60000;
    localparam bit RpmEnabled = 1'b1;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegStartThr = 3'd0;
    localparam logic [CfgIdxW-1:0] RegMaxCrank = 3'd1;
    localparam logic [CfgIdxW-1:0] RegCooldown = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRunRpm = 3'd3;
    localparam logic [CfgIdxW-1:0] RegConfirm = 3'd4;
    localparam logic [CfgIdxW-1:0] RegWindow = 3'd5;
    localparam logic [CfgIdxW-1:0] RegSpr = 3'd6;
    localparam logic [CfgIdxW-1:0] RegKill = 3'd7;

    // Phase codes
    localparam logic [2:0] PhOff = 3'd0;
    localparam logic [2:0] PhCrank = 3'd1;
    localparam logic [2:0] PhRun = 3'd2;
    localparam logic [2:0] PhCool = 3'd3;
    localparam logic [2:0] PhStall = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic measure;    // add sparks and count the window
        logic div_start;  // launch RPM division
        logic step;       // apply phase step / kill handling
    } esc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic window_done;  // window closed, division needed
        logic div_busy;     // division in progress
    } esc_status_t;

endpackage

### src/esc_divider.sv
// ============================================================================
// esc_divider: iterative restoring divider
// One quotient bit per cycle; result saturated to 16 bits.
// ============================================================================
module esc_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [esc_pkg::DivW-1:0]    dividend,
    input  logic [esc_pkg::DenW-1:0]    divisor,
    output logic                        busy,
    output logic [esc_pkg::RpmW-1:0]    quotient
);

    localparam int unsigned CntW = $clog2(esc_pkg::DivW + 1);

    logic [esc_pkg::DivW-1:0] quo_reg, quo_next;
    logic [esc_pkg::DenW:0]   rem_reg, rem_next;
    logic [esc_pkg::DenW-1:0] den_reg;
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic [esc_pkg::DenW:0]   trial;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[esc_pkg::DenW-1:0], quo_reg[esc_pkg::DivW-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CntW'(esc_pkg::DivW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[esc_pkg::DivW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[esc_pkg::DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= divisor;
    end

    assign busy = busy_reg;
    assign quotient = (|quo_reg[esc_pkg::DivW-1:esc_pkg::RpmW]) ? '1
                                                               : quo_reg[esc_pkg::RpmW-1:0];

endmodule

### src/esc_datapath.sv
// ============================================================================
// esc_datapath: registers, timers, RPM measurement and phase logic
// Executes commands from the controller; owns all engine state.
// ============================================================================
module esc_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [esc_pkg::CfgIdxW-1:0]        cfg_addr,
    input  logic [esc_pkg::CfgDataW-1:0]       cfg_data,
    input  logic [17:0]                        in_data,
    input  esc_pkg::esc_cmd_t                  cmd,
    output esc_pkg::esc_status_t               status,
    output logic [20:0]                        result
);

    // Configuration registers
    logic [11:0] thr_reg;
    logic [15:0] max_crank_reg, cool_reg, run_rpm_reg, confirm_reg, window_reg, kill_len_reg;
    logic [4:0]  spr_reg;

    // Captured item
    logic        kcmd_reg;
    logic [3:0]  edges_reg;

    // Engine state
    logic [2:0]                  phase_reg, phase_next;
    logic                        req_reg, req_next, relay_reg, relay_next;
    logic                        armed_reg, armed_next;
    logic [esc_pkg::TimerW-1:0]  crank_reg, crank_next, coolt_reg, coolt_next;
    logic [esc_pkg::TimerW-1:0]  conf_reg, conf_next;
    logic [15:0]                 kill_reg, kill_next;
    logic [15:0]                 win_reg, win_next;
    logic [esc_pkg::TotalW-1:0]  total_reg, total_next;
    logic [esc_pkg::RpmW-1:0]    rpm_reg;
    logic                        wdone_reg, wdone_next;
    logic                        div_pend_reg;

    logic [esc_pkg::TotalW:0]    sum;
    logic [15:0]                 win_eff;
    logic [4:0]                  spr_eff;
    logic [esc_pkg::TimerW-1:0]  crank_inc, conf_inc, cool_inc;
    logic [esc_pkg::DivW-1:0]    dividend;
    logic [esc_pkg::DenW-1:0]    divisor;
    logic                        div_busy;
    logic [esc_pkg::RpmW-1:0]    div_q;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 12'd1500;
            max_crank_reg <= 16'd3000;
            cool_reg <= 16'd5000;
            run_rpm_reg <= 16'd500;
            confirm_reg <= 16'd500;
            window_reg <= 16'd100;
            spr_reg <= 5'd1;
            kill_len_reg <= 16'd200;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                esc_pkg::RegStartThr: thr_reg <= cfg_data[11:0];
                esc_pkg::RegMaxCrank: max_crank_reg <= cfg_data;
                esc_pkg::RegCooldown: cool_reg <= cfg_data;
                esc_pkg::RegRunRpm:   run_rpm_reg <= cfg_data;
                esc_pkg::RegConfirm:  confirm_reg <= cfg_data;
                esc_pkg::RegWindow:   window_reg <= cfg_data;
                esc_pkg::RegSpr:      spr_reg <= cfg_data[4:0];
                esc_pkg::RegKill:     kill_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kcmd_reg <= in_data[0];
            edges_reg <= in_data[17:14];
        end
    end

    assign win_eff = (window_reg == '0) ? 16'd1 : window_reg;
    assign spr_eff = (spr_reg == '0) ? 5'd1 : spr_reg;
    assign sum = {1'b0, total_reg} + {17'd0, edges_reg};

    // Measurement step: accumulate sparks, count window
    always_comb
    begin
        total_next = total_reg;
        win_next = win_reg;
        wdone_next = wdone_reg;
        if (cmd.measure)
        begin
            total_next = sum[esc_pkg::TotalW] ? esc_pkg::TotalMax
                                              : sum[esc_pkg::TotalW-1:0];
            win_next = (win_reg != 16'hFFFF) ? win_reg + 16'd1 : win_reg;
            wdone_next = (win_next >= win_eff);
        end
        else if (cmd.div_start)
            wdone_next = 1'b0;
    end

    assign dividend = esc_pkg::DivW'(total_reg) * esc_pkg::DivW'(esc_pkg::RpmScale);
    assign divisor = esc_pkg::DenW'(spr_eff) * esc_pkg::DenW'(win_reg);

    esc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign crank_inc = (crank_reg != esc_pkg::TimerMax) ? crank_reg + 1'b1 : crank_reg;
    assign conf_inc = (conf_reg != esc_pkg::TimerMax) ? conf_reg + 1'b1 : conf_reg;
    assign cool_inc = (coolt_reg != esc_pkg::TimerMax) ? coolt_reg + 1'b1 : coolt_reg;

    // Phase step, kill handling and start request
    always_comb
    begin
        phase_next = phase_reg;
        req_next = req_reg;
        relay_next = relay_reg;
        armed_next = armed_reg;
        crank_next = crank_reg;
        coolt_next = coolt_reg;
        conf_next = conf_reg;
        kill_next = kill_reg;
        if (cmd.step)
        begin
            if (kcmd_reg)
            begin
                crank_next = '0;
                if (phase_reg == esc_pkg::PhRun)
                    kill_next = kill_len_reg;
                relay_next = 1'b0;
                armed_next = 1'b0;
                conf_next = '0;
                phase_next = esc_pkg::PhOff;
            end
            else if (kill_reg != '0)
            begin
                kill_next = kill_reg - 16'd1;
            end
            else
            begin
                case (phase_reg)
                    esc_pkg::PhOff:
                    begin
                        if (req_reg)
                        begin
                            relay_next = 1'b1;
                            crank_next = '0;
                            phase_next = esc_pkg::PhCrank;
                        end
                    end
                    esc_pkg::PhCrank:
                    begin
                        crank_next = crank_inc;
                        if (esc_pkg::RpmEnabled)
                        begin
                            if (rpm_reg > run_rpm_reg)
                            begin
                                if (!armed_reg)
                                begin
                                    armed_next = 1'b1;
                                    conf_next = '0;
                                end
                                else
                                    conf_next = conf_inc;
                            end
                            else
                            begin
                                armed_next = 1'b0;
                                conf_next = '0;
                            end
                        end
                        if (esc_pkg::RpmEnabled && rpm_reg > run_rpm_reg && armed_reg
                            && conf_inc >= {1'b0, confirm_reg})
                            phase_next = esc_pkg::PhRun;
                        else if (crank_inc > {1'b0, max_crank_reg})
                        begin
                            phase_next = esc_pkg::RpmEnabled ? esc_pkg::PhCool
                                                             : esc_pkg::PhRun;
                            if (esc_pkg::RpmEnabled)
                                coolt_next = '0;
                        end
                        else if (!req_reg)
                            phase_next = esc_pkg::PhOff;
                        if (phase_next != esc_pkg::PhCrank)
                        begin
                            relay_next = 1'b0;
                            armed_next = 1'b0;
                            conf_next = '0;
                        end
                    end
                    esc_pkg::PhRun:
                    begin
                        if (esc_pkg::RpmEnabled && rpm_reg < run_rpm_reg)
                            phase_next = esc_pkg::PhStall;
                        if (!req_reg)
                        begin
                            kill_next = kill_len_reg;
                            phase_next = esc_pkg::PhOff;
                        end
                    end
                    esc_pkg::PhCool:
                    begin
                        coolt_next = cool_inc;
                        if (cool_inc > {1'b0, cool_reg})
                            phase_next = esc_pkg::PhOff;
                    end
                    esc_pkg::PhStall:
                    begin
                        if (!req_reg)
                            phase_next = esc_pkg::PhOff;
                    end
                    default: phase_next = esc_pkg::PhOff;
                endcase
            end
        end
        else if (cmd.load && !in_data[0] && in_data[1])
            req_next = (in_data[13:2] > thr_reg);
    end

    // Hold engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esc_pkg::PhOff;
            req_reg <= 1'b0;
            relay_reg <= 1'b0;
            armed_reg <= 1'b0;
            crank_reg <= '0;
            coolt_reg <= '0;
            conf_reg <= '0;
            kill_reg <= '0;
            win_reg <= '0;
            total_reg <= '0;
            rpm_reg <= '0;
            wdone_reg <= 1'b0;
            div_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            req_reg <= req_next;
            relay_reg <= relay_next;
            armed_reg <= armed_next;
            crank_reg <= crank_next;
            coolt_reg <= coolt_next;
            conf_reg <= conf_next;
            kill_reg <= kill_next;
            wdone_reg <= wdone_next;
            if (cmd.div_start)
            begin
                total_reg <= '0;
                win_reg <= '0;
                div_pend_reg <= 1'b1;
            end
            else
            begin
                total_reg <= total_next;
                win_reg <= win_next;
            end
            if (div_pend_reg && !div_busy && !cmd.div_start)
            begin
                rpm_reg <= div_q;
                div_pend_reg <= 1'b0;
            end
        end
    end

    assign status.window_done = wdone_reg;
    assign status.div_busy = div_busy || div_pend_reg;
    assign result = {rpm_reg, (kill_reg != '0), relay_reg, phase_reg};

`ifndef SYNTHESIS
    a_relay_crank: assert property (@(posedge clk) disable iff (!rst_n)
        relay_reg |-> (phase_reg == esc_pkg::PhCrank))
        else $error("relay on outside cranking");
    a_armed_crank: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (phase_reg == esc_pkg::PhCrank))
        else $error("confirm armed outside cranking");
    a_div_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (win_reg == '0 && total_reg == '0))
        else $error("window not cleared on division start");
`endif

endmodule

### src/esc_controller.sv
// ============================================================================
// esc_controller: sequencing state machine
// Accepts an item, runs measurement (skipped for a kill), division when the window
// closes, and the phase step, then presents the result.
// ============================================================================
module esc_controller
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_kill,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output esc_pkg::esc_cmd_t     cmd,
    input  esc_pkg::esc_status_t  status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEASURE,
        S_CHECK,
        S_DIV,
        S_STEP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = in_kill ? S_STEP : S_MEASURE;
                end
            end
            S_MEASURE:
            begin
                cmd.measure = esc_pkg::RpmEnabled;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.window_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_STEP;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.measure, cmd.div_start, cmd.step}))
        else $error("overlapping commands");
    a_kill_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && in_kill) |=> state_reg == S_STEP)
        else $error("kill item went through measurement");
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid)
        else $error("result not presented after step");
`endif

endmodule

### src/engine_start_controller_core.sv
// ============================================================================
// engine_start_controller_core: engine start controller top level
// One millisecond tick or kill command in, one status item out.
// ============================================================================
// Sequence: a tick is measured and then stepped, with a bit-serial RPM division
// in between when the window closes; a kill goes straight to the phase step.
// Throughput: one item at a time; the next is taken after the result transfer.
// Reset: asynchronous, active low; phase off, timers and counters cleared,
// configuration registers return to their default values.
module engine_start_controller_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,   // cmd
    input  logic [23:0] s_tdata,   // pulse_valid, rc_pulse_us[12:1], spark_edges[16:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // engine_phase, starter_relay, ignition_kill, engine_rpm
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    esc_pkg::esc_cmd_t    cmd;
    esc_pkg::esc_status_t status;
    logic [20:0]          result;

    esc_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_kill   (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    esc_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_data  ({s_tdata[16:0], s_tuser[0]}),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

    assign m_tdata = {3'd0, result};

endmodule

### tb/esc_checker.sv
// ============================================================================
// esc_checker: status predictor and comparator for the engine start controller
// Watches the input, output and register write ports, works out the status
// item each accepted tick or kill should produce, and compares in order.
// ============================================================================
module esc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [0:0]  s_tuser,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    // packed from the top bit down: rpm, kill, relay, phase
    typedef struct packed {
        logic [15:0] rpm;
        logic        kill;
        logic        relay;
        logic [2:0]  phase;
    } status_t;

    status_t status_q[$];

    // register copies
    logic [11:0] thr_us;
    logic [15:0] max_crank, cool_ms, run_rpm, conf_ms, win_ms, kill_ms;
    logic [4:0]  spr;

    // controller state copy
    logic [2:0]  ph;
    logic        req_flag, relay, armed;
    int unsigned crank_t, cool_t, conf_t, win_t, sparks, rpm, kill_left;

    function automatic int unsigned bump(int unsigned v);
        return (v < esc_pkg::TimerMax) ? v + 1 : esc_pkg::TimerMax;
    endfunction

    // Close the cranking phase and move on
    task automatic end_crank(logic [2:0] nxt);
        relay = 1'b0;
        armed = 1'b0;
        conf_t = 0;
        ph = nxt;
    endtask

    task automatic advance_phase();
        case (ph)
            esc_pkg::PhOff:
                if (req_flag)
                begin
                    relay = 1'b1;
                    crank_t = 0;
                    ph = esc_pkg::PhCrank;
                end
            esc_pkg::PhCrank:
            begin
                crank_t = bump(crank_t);
                if (rpm > run_rpm)
                begin
                    if (!armed)
                    begin
                        armed = 1'b1;
                        conf_t = 0;
                    end
                    else
                    begin
                        conf_t = bump(conf_t);
                        if (conf_t >= conf_ms)
                        begin
                            end_crank(esc_pkg::PhRun);
                            return;
                        end
                    end
                end
                else
                begin
                    armed = 1'b0;
                    conf_t = 0;
                end
                if (crank_t > max_crank)
                begin
                    cool_t = 0;
                    end_crank(esc_pkg::PhCool);
                    return;
                end
                if (!req_flag)
                    end_crank(esc_pkg::PhOff);
            end
            esc_pkg::PhRun:
            begin
                if (rpm < run_rpm)
                    ph = esc_pkg::PhStall;
                if (!req_flag)
                begin
                    kill_left = kill_ms;
                    ph = esc_pkg::PhOff;
                end
            end
            esc_pkg::PhCool:
            begin
                cool_t = bump(cool_t);
                if (cool_t > cool_ms)
                    ph = esc_pkg::PhOff;
            end
            esc_pkg::PhStall:
                if (!req_flag)
                    ph = esc_pkg::PhOff;
            default:
                ph = esc_pkg::PhOff;
        endcase
    endtask

    // Work out the status for one accepted transfer
    task automatic predict_status(logic kill_cmd, logic [23:0] d);
        longint unsigned q, den;
        int unsigned w, s;
        status_t st;
        if (kill_cmd)
        begin
            crank_t = 0;
            if (ph == esc_pkg::PhRun)
                kill_left = kill_ms;
            end_crank(esc_pkg::PhOff);
        end
        else
        begin
            if (d[0])
                req_flag = (d[12:1] > thr_us);
            w = (win_ms == 0) ? 1 : win_ms;
            s = (spr == 0) ? 1 : spr;
            sparks = sparks + d[16:13];
            if (sparks > esc_pkg::TotalMax)
                sparks = esc_pkg::TotalMax;
            if (win_t < 65535)
                win_t++;
            if (win_t >= w)
            begin
                den = longint'(s) * win_t;
                q = (longint'(sparks) * 60000) / den;
                rpm = (q > 65535) ? 65535 : int'(q);
                sparks = 0;
                win_t = 0;
            end
            if (kill_left > 0)
                kill_left--;
            else
                advance_phase();
        end
        st.phase = ph;
        st.relay = relay;
        st.kill = (kill_left > 0);
        st.rpm = rpm[15:0];
        status_q.push_back(st);
    endtask

    assign pending = status_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        status_t got, exp_st;
        if (!rst_n)
        begin
            thr_us = 12'd1500; max_crank = 16'd3000; cool_ms = 16'd5000;
            run_rpm = 16'd500; conf_ms = 16'd500; win_ms = 16'd100;
            spr = 5'd1; kill_ms = 16'd200;
            ph = esc_pkg::PhOff; req_flag = 0; relay = 0; armed = 0;
            crank_t = 0; cool_t = 0; conf_t = 0; win_t = 0;
            sparks = 0; rpm = 0; kill_left = 0;
            fail_count = 0;
            status_q.delete();
        end
        else
        begin
            // compare the output transfer first, it belongs to an older item
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[20:0];
                if (status_q.size() == 0)
                begin
                    $error("unexpected status transfer %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_st = status_q.pop_front();
                    if (got.phase !== exp_st.phase)
                    begin
                        $error("engine_phase expected %0d got %0d", exp_st.phase, got.phase);
                        fail_count++;
                    end
                    if (got.relay !== exp_st.relay)
                    begin
                        $error("starter_relay expected %0d got %0d", exp_st.relay, got.relay);
                        fail_count++;
                    end
                    if (got.kill !== exp_st.kill)
                    begin
                        $error("ignition_kill expected %0d got %0d", exp_st.kill, got.kill);
                        fail_count++;
                    end
                    if (got.rpm !== exp_st.rpm)
                    begin
                        $error("engine_rpm expected %0d got %0d", exp_st.rpm, got.rpm);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_status(s_tuser[0], s_tdata);
            // track register writes
            if (cfg_we)
                case (cfg_addr)
                    esc_pkg::RegStartThr: thr_us = cfg_data[11:0];
                    esc_pkg::RegMaxCrank: max_crank = cfg_data;
                    esc_pkg::RegCooldown: cool_ms = cfg_data;
                    esc_pkg::RegRunRpm:   run_rpm = cfg_data;
                    esc_pkg::RegConfirm:  conf_ms = cfg_data;
                    esc_pkg::RegWindow:   win_ms = cfg_data;
                    esc_pkg::RegSpr:      spr = cfg_data[4:0];
                    esc_pkg::RegKill:     kill_ms = cfg_data;
                    default: ;
                endcase
        end
    end

endmodule

### tb/tb.sv
// ============================================================================
// tb: engine start controller testbench
// Drives ticks and kill commands with random gaps, reprograms the registers
// between phases and leaves prediction and comparison to the checker.
// ============================================================================
module tb;

    localparam int CycleLimit = 600000;

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [0:0]  s_tuser;
    logic [23:0] s_tdata, m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_data;
    int          fail_count, pending;
    int          sent_count;
    int          cycles;
    logic [11:0] cur_thr;
    bit          held;

    engine_start_controller_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    esc_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 40) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // Receiver: random stalls plus one long hold-off mid run
    initial
    begin
        int g;
        m_tready = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_count >= 250)
            begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            g = pick_gap();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Offer one transfer, holding valid across back-to-back items
    task automatic send_item(logic kill_cmd, logic pv, logic [11:0] rc, logic [3:0] sp);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kill_cmd;
        s_tdata <= {7'd0, sp, rc, pv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_tick();
        logic pv;
        logic [11:0] rc;
        pv = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 99) < 65)
            rc = (cur_thr == 12'hFFF) ? 12'hFFF : 12'($urandom_range(cur_thr + 1, 4095));
        else
            rc = 12'($urandom_range(0, cur_thr));
        if ($urandom_range(0, 99) < 10)
            rc = 12'($urandom);
        send_item(($urandom_range(0, 99) < 3), pv, rc, 4'($urandom));
    endtask

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        if (idx == esc_pkg::RegStartThr)
            cur_thr = val[11:0];
        @(posedge clk);
    endtask

    // Drain all expected status and let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] short_or_max(int hi);
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, hi));
    endfunction

    initial
    begin
        int n;
        rst_n = 0;
        s_tvalid = 0; s_tuser = 0; s_tdata = 0;
        cfg_we = 0; cfg_addr = 0; cfg_data = 0;
        sent_count = 0; cycles = 0;
        cur_thr = 12'd1500;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fast settings to walk through every phase
        set_reg(esc_pkg::RegWindow, 16'd0);
        set_reg(esc_pkg::RegConfirm, 16'd2);
        set_reg(esc_pkg::RegMaxCrank, 16'd6);
        set_reg(esc_pkg::RegCooldown, 16'd2);
        set_reg(esc_pkg::RegKill, 16'd3);
        set_reg(esc_pkg::RegRunRpm, 16'd1000);
        cfg_we <= 1'b0;
        wait_idle();
        send_item(0, 1, 12'hFFF, 4'hF);  // request, saturated rpm
        send_item(0, 0, 12'd0, 4'hF);
        send_item(0, 0, 12'd0, 4'hF);
        send_item(0, 0, 12'd0, 4'hF);    // confirmed running
        send_item(0, 0, 12'd0, 4'd0);    // rpm drops, stall
        send_item(0, 1, 12'd1500, 4'd0); // threshold not exceeded, drop
        send_item(0, 1, 12'd1501, 4'hF);
        send_item(0, 0, 12'd0, 4'hF);
        send_item(0, 0, 12'd0, 4'hF);
        send_item(0, 0, 12'd0, 4'hF);
        send_item(1, 1, 12'hFFF, 4'hF);  // emergency kill while running
        send_item(0, 0, 12'd0, 4'd0);
        send_item(0, 0, 12'd0, 4'd0);
        send_item(0, 0, 12'd0, 4'd0);
        for (n = 0; n < 10; n++)
            send_item(0, 0, 12'd0, 4'd0); // crank timeout into cooldown
        send_item(1, 0, 12'd0, 4'd0);
        wait_idle();
        // window shortened while partly counted
        set_reg(esc_pkg::RegWindow, 16'd65535);
        cfg_we <= 1'b0;
        send_item(0, 0, 12'd0, 4'hF);
        send_item(0, 0, 12'd0, 4'hF);
        wait_idle();
        set_reg(esc_pkg::RegWindow, 16'd1);
        set_reg(esc_pkg::RegSpr, 16'd0);
        cfg_we <= 1'b0;
        send_item(0, 0, 12'd0, 4'hA);
        send_item(0, 0, 12'd0, 4'h5);
        wait_idle();

        // Random phases with new settings each time
        for (int p = 0; p < 10; p++)
        begin
            set_reg(esc_pkg::RegStartThr,
                    (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom));
            set_reg(esc_pkg::RegMaxCrank, short_or_max(40));
            set_reg(esc_pkg::RegCooldown, short_or_max(20));
            set_reg(esc_pkg::RegRunRpm, (p == 2) ? 16'hFFFF : 16'($urandom_range(0, 30000)));
            set_reg(esc_pkg::RegConfirm, short_or_max(8));
            set_reg(esc_pkg::RegWindow, (p == 3) ? 16'hFFFF : 16'($urandom_range(0, 5)));
            set_reg(esc_pkg::RegSpr,
                    (p == 4) ? 16'd31 : (p == 5) ? 16'd16 : 16'($urandom_range(0, 31)));
            set_reg(esc_pkg::RegKill, (p == 6) ? 16'hFFFF : 16'($urandom_range(0, 8)));
            cfg_we <= 1'b0;
            for (n = 0; n < 50; n++)
                send_tick();
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
src/esc_pkg.sv
src/esc_divider.sv
src/esc_datapath.sv
src/esc_controller.sv
src/engine_start_controller_core.sv
tb/esc_checker.sv
tb/tb.sv
